FILE: hw/rtl/gdrp_pkg.sv
// Shared types and constants of the group data record parser.
package gdrp_pkg;

  localparam int unsigned CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [0:0] REG_MAX_ADMINS = 1'b0;
  localparam logic [0:0] REG_MAX_RELAYS = 1'b1;

  localparam logic [9:0] MAX_ADMINS_RESET = 10'd1000;
  localparam logic [6:0] MAX_RELAYS_RESET = 7'd100;

  // Lengths of the fixed-size fields.
  localparam logic [31:0] KEY_LEN   = 32'd32;
  localparam logic [31:0] NONCE_LEN = 32'd12;

  typedef enum logic [4:0] {
    PH_VER     = 5'd0,
    PH_ID      = 5'd1,
    PH_NAMELEN = 5'd2,
    PH_NAME    = 5'd3,
    PH_DESCLEN = 5'd4,
    PH_DESC    = 5'd5,
    PH_ADMLEN  = 5'd6,
    PH_ADM     = 5'd7,
    PH_RELLEN  = 5'd8,
    PH_URLLEN  = 5'd9,
    PH_URL     = 5'd10,
    PH_IMGFLAG = 5'd11,
    PH_HASH    = 5'd12,
    PH_IKEY    = 5'd13,
    PH_NONCE   = 5'd14,
    PH_UPFLAG  = 5'd15,
    PH_UPKEY   = 5'd16,
    PH_DONE    = 5'd17,
    PH_ERR     = 5'd18
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_REJECT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE            = 3'd0,
    ERR_TRUNCATED       = 3'd1,
    ERR_BAD_VERSION     = 3'd2,
    ERR_ADMIN_ALIGN     = 3'd3,
    ERR_TOO_MANY_ADMINS = 3'd4,
    ERR_RELAY_OVERRUN   = 3'd5,
    ERR_TOO_MANY_RELAYS = 3'd6
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] bytes_left;
    logic [31:0] length_accum;
    logic [31:0] relay_vector_left;
    logic [1:0]  record_version;
    logic [6:0]  urls_seen;
    err_t        failed_code;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:             PH_VER,
    bytes_left:        32'd0,
    length_accum:      32'd0,
    relay_vector_left: 32'd0,
    record_version:    2'd0,
    urls_seen:         7'd0,
    failed_code:       ERR_NONE
  };

  typedef struct packed {
    logic [4:0]  field_id;
    logic [7:0]  byte_value;
    logic [9:0]  entry_index;
    logic [15:0] field_offset;
    logic [1:0]  status;
    logic [2:0]  error_code;
  } result_t;

endpackage

FILE: hw/rtl/gdrp_if.sv
// Valid/ready channel interfaces for the parser's input bytes and labeled results.
interface gdrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gdrp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [7:0]  byte_value;
  logic [9:0]  entry_index;
  logic [15:0] field_offset;
  logic [1:0]  status;
  logic [2:0]  error_code;

  modport source (
    output valid, output field_id, output byte_value, output entry_index,
    output field_offset, output status, output error_code, input ready
  );
  modport sink (
    input valid, input field_id, input byte_value, input entry_index,
    input field_offset, input status, input error_code, output ready
  );
endinterface

FILE: hw/rtl/gdrp_step.sv
// Per-byte parse step: next parser state and the labeled result for one byte.
module gdrp_step (
  input  gdrp_pkg::parse_state_t st,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic [9:0]             max_admins,
  input  logic [6:0]             max_relays,
  output gdrp_pkg::parse_state_t nxt,
  output gdrp_pkg::result_t      res
);
  import gdrp_pkg::*;

  logic [15:0] acc16;
  logic [31:0] acc32;
  logic [31:0] bl_inc;
  logic [31:0] bl_dec;
  logic [31:0] adm_done;
  logic [15:0] body_off;
  logic [31:0] rvl_dec;
  logic        do_fail;
  err_t        fail_code;
  phase_t      len_next;

  assign acc16    = {st.length_accum[7:0], data_byte};
  assign acc32    = {st.length_accum[23:0], data_byte};
  assign bl_inc   = st.bytes_left + 32'd1;
  assign bl_dec   = st.bytes_left - 32'd1;
  assign adm_done = st.length_accum - st.bytes_left;
  assign body_off = st.length_accum[15:0] - st.bytes_left[15:0];
  assign rvl_dec  = st.relay_vector_left - 32'd1;

  always_comb begin
    nxt       = st;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    len_next  = PH_DESCLEN;
    res.field_id     = 5'(PH_DONE);
    res.byte_value   = data_byte;
    res.entry_index  = 10'd0;
    res.field_offset = 16'd0;
    res.status       = 2'(ST_CONTINUE);
    res.error_code   = 3'(ERR_NONE);

    unique case (st.phase)
      PH_VER: begin
        res.field_id     = 5'(PH_VER);
        res.field_offset = st.bytes_left[15:0];
        nxt.length_accum = {16'd0, acc16};
        nxt.bytes_left   = bl_inc;
        if (bl_inc >= 32'd2) begin
          if (acc16 < 16'd1 || acc16 > 16'd2) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_VERSION;
          end else begin
            nxt.record_version = acc16[1:0];
            nxt.phase          = PH_ID;
            nxt.bytes_left     = KEY_LEN;
            nxt.length_accum   = 32'd0;
          end
        end
      end
      PH_ID, PH_HASH, PH_IKEY, PH_NONCE, PH_UPKEY: begin
        res.field_id = 5'(st.phase);
        if (st.phase == PH_NONCE) begin
          res.field_offset = NONCE_LEN[15:0] - st.bytes_left[15:0];
        end else begin
          res.field_offset = KEY_LEN[15:0] - st.bytes_left[15:0];
        end
        nxt.bytes_left = bl_dec;
        if (bl_dec == 32'd0) begin
          nxt.length_accum = 32'd0;
          priority if (st.phase == PH_ID) begin
            nxt.phase = PH_NAMELEN;
          end else if (st.phase == PH_HASH) begin
            nxt.phase      = PH_IKEY;
            nxt.bytes_left = KEY_LEN;
          end else if (st.phase == PH_IKEY) begin
            nxt.phase      = PH_NONCE;
            nxt.bytes_left = NONCE_LEN;
          end else if (st.phase == PH_NONCE && st.record_version == 2'd2) begin
            nxt.phase = PH_UPFLAG;
          end else begin
            nxt.phase = PH_DONE;
          end
        end
      end
      PH_NAMELEN, PH_DESCLEN: begin
        res.field_id     = 5'(st.phase);
        res.field_offset = st.bytes_left[15:0];
        len_next         = (st.phase == PH_NAMELEN) ? PH_DESCLEN : PH_ADMLEN;
        nxt.length_accum = {16'd0, acc16};
        nxt.bytes_left   = bl_inc;
        if (bl_inc >= 32'd2) begin
          if (acc16 == 16'd0) begin
            nxt.phase        = len_next;
            nxt.bytes_left   = 32'd0;
            nxt.length_accum = 32'd0;
          end else begin
            // The body phase directly follows its length phase.
            nxt.phase      = (st.phase == PH_NAMELEN) ? PH_NAME : PH_DESC;
            nxt.bytes_left = {16'd0, acc16};
          end
        end
      end
      PH_NAME, PH_DESC: begin
        res.field_id     = 5'(st.phase);
        res.field_offset = body_off;
        nxt.bytes_left   = bl_dec;
        if (bl_dec == 32'd0) begin
          nxt.phase        = (st.phase == PH_NAME) ? PH_DESCLEN : PH_ADMLEN;
          nxt.length_accum = 32'd0;
        end
      end
      PH_ADMLEN: begin
        res.field_id     = 5'(PH_ADMLEN);
        res.field_offset = st.bytes_left[15:0];
        nxt.length_accum = acc32;
        nxt.bytes_left   = bl_inc;
        if (bl_inc >= 32'd4) begin
          if (acc32[4:0] != 5'd0) begin
            do_fail   = 1'b1;
            fail_code = ERR_ADMIN_ALIGN;
          end else if (acc32[31:5] > {17'd0, max_admins}) begin
            do_fail   = 1'b1;
            fail_code = ERR_TOO_MANY_ADMINS;
          end else if (acc32 == 32'd0) begin
            nxt.phase        = PH_RELLEN;
            nxt.bytes_left   = 32'd0;
            nxt.length_accum = 32'd0;
          end else begin
            nxt.phase      = PH_ADM;
            nxt.bytes_left = acc32;
          end
        end
      end
      PH_ADM: begin
        res.field_id     = 5'(PH_ADM);
        res.entry_index  = adm_done[14:5];
        res.field_offset = {11'd0, adm_done[4:0]};
        nxt.bytes_left   = bl_dec;
        if (bl_dec == 32'd0) begin
          nxt.phase        = PH_RELLEN;
          nxt.length_accum = 32'd0;
        end
      end
      PH_RELLEN: begin
        res.field_id     = 5'(PH_RELLEN);
        res.field_offset = st.bytes_left[15:0];
        nxt.length_accum = acc32;
        nxt.bytes_left   = bl_inc;
        if (bl_inc >= 32'd4) begin
          nxt.relay_vector_left = acc32;
          nxt.urls_seen         = 7'd0;
          nxt.phase             = (acc32 == 32'd0) ? PH_IMGFLAG : PH_URLLEN;
          nxt.bytes_left        = 32'd0;
          nxt.length_accum      = 32'd0;
        end
      end
      PH_URLLEN: begin
        res.field_id     = 5'(PH_URLLEN);
        res.entry_index  = {3'd0, st.urls_seen};
        res.field_offset = st.bytes_left[15:0];
        if (st.bytes_left == 32'd0 && st.relay_vector_left < 32'd2) begin
          do_fail   = 1'b1;
          fail_code = ERR_RELAY_OVERRUN;
        end else begin
          nxt.relay_vector_left = rvl_dec;
          nxt.length_accum      = {16'd0, acc16};
          nxt.bytes_left        = bl_inc;
          if (bl_inc >= 32'd2) begin
            if ({16'd0, acc16} > rvl_dec) begin
              do_fail   = 1'b1;
              fail_code = ERR_RELAY_OVERRUN;
            end else if (st.urls_seen >= max_relays) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOO_MANY_RELAYS;
            end else begin
              nxt.urls_seen = st.urls_seen + 7'd1;
              if (acc16 != 16'd0) begin
                nxt.phase      = PH_URL;
                nxt.bytes_left = {16'd0, acc16};
              end else begin
                nxt.phase        = (rvl_dec == 32'd0) ? PH_IMGFLAG : PH_URLLEN;
                nxt.bytes_left   = 32'd0;
                nxt.length_accum = 32'd0;
              end
            end
          end
        end
      end
      PH_URL: begin
        res.field_id = 5'(PH_URL);
        res.entry_index = (st.urls_seen != 7'd0) ?
                          {3'd0, st.urls_seen - 7'd1} : 10'd0;
        res.field_offset      = body_off;
        nxt.bytes_left        = bl_dec;
        nxt.relay_vector_left = rvl_dec;
        if (bl_dec == 32'd0) begin
          nxt.phase        = (rvl_dec == 32'd0) ? PH_IMGFLAG : PH_URLLEN;
          nxt.length_accum = 32'd0;
        end
      end
      PH_IMGFLAG, PH_UPFLAG: begin
        res.field_id     = 5'(st.phase);
        nxt.length_accum = 32'd0;
        if (data_byte != 8'd0) begin
          nxt.phase      = (st.phase == PH_IMGFLAG) ? PH_HASH : PH_UPKEY;
          nxt.bytes_left = KEY_LEN;
        end else begin
          nxt.phase      = PH_DONE;
          nxt.bytes_left = 32'd0;
        end
      end
      PH_DONE: begin
        res.field_id     = 5'(PH_DONE);
        res.field_offset = st.length_accum[15:0];
        if (st.length_accum[15:0] != 16'hFFFF) begin
          nxt.length_accum = st.length_accum + 32'd1;
        end
      end
      default: begin
        res.field_id = 5'(PH_DONE);
        nxt.phase    = PH_ERR;
      end
    endcase

    if (do_fail) begin
      nxt.phase = PH_ERR;
      if (st.failed_code == ERR_NONE) begin
        nxt.failed_code = fail_code;
      end
    end

    if (last_byte) begin
      if (nxt.phase == PH_DONE && nxt.failed_code == ERR_NONE) begin
        res.status = 2'(ST_ACCEPT);
      end else begin
        if (nxt.phase != PH_ERR) begin
          nxt.phase = PH_ERR;
          if (nxt.failed_code == ERR_NONE) begin
            nxt.failed_code = ERR_TRUNCATED;
          end
        end
        res.status = 2'(ST_REJECT);
      end
    end

    res.error_code = 3'(nxt.failed_code);

    // The next message starts from a clean parse state.
    if (last_byte) begin
      nxt = PARSE_RESET;
    end
  end

endmodule

FILE: hw/rtl/group_data_record_parser_core.sv
// Top level of the streaming group data record parser and checker.
//
// The core takes a serialized group data record one byte per item, with a
// last-byte mark, and returns one result item per byte: the field the byte
// belongs to, the byte itself, the admin or relay entry number, the offset
// within the field or entry, a status that reports accept or reject on the
// last byte, and the sticky error code of the message. The first error
// stops parsing; every later byte of that message is labeled trailing. At
// the last byte the parse state returns to its reset value, so messages can
// follow one another with no gap. The core sustains one byte per clock
// cycle while the result side does not stall: a byte is captured in an
// input register, the parse step between it and the result register
// updates the phase and counters, and both registers advance together
// whenever the result register is empty or being drained. A byte's result
// is presented from the result register and stays there while the result
// side stalls. The user must write the max_admins and max_relays registers
// through cfg only while no message is in flight; the core does not check.
module group_data_record_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  gdrp_in_if.sink                            in_ch,
  gdrp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [gdrp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gdrp_pkg::*;

  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_v_r;
  result_t      res_r;
  parse_state_t st_r;
  logic [9:0]   max_admins_r;
  logic [6:0]   max_relays_r;

  parse_state_t st_nxt;
  result_t      res_nxt;
  logic         advance;
  logic         in_ready;

  // Both stages move when the result register can take a new item.
  assign advance  = !out_v_r || out_ch.ready;
  assign in_ready = !in_v_r || advance;

  assign in_ch.ready = in_ready;

  gdrp_step u_step (
    .st         (st_r),
    .data_byte  (in_byte_r),
    .last_byte  (in_last_r),
    .max_admins (max_admins_r),
    .max_relays (max_relays_r),
    .nxt        (st_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      st_r         <= PARSE_RESET;
      max_admins_r <= MAX_ADMINS_RESET;
      max_relays_r <= MAX_RELAYS_RESET;
    end else begin
      if (in_ready) begin
        in_v_r <= in_ch.valid;
      end
      if (in_v_r && advance) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_ADMINS: max_admins_r <= cfg_wdata[9:0];
          REG_MAX_RELAYS: max_relays_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
    if (in_v_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.field_id     = res_r.field_id;
  assign out_ch.byte_value   = res_r.byte_value;
  assign out_ch.entry_index  = res_r.entry_index;
  assign out_ch.field_offset = res_r.field_offset;
  assign out_ch.status       = res_r.status;
  assign out_ch.error_code   = res_r.error_code;

endmodule
